[design/sta_pkg.sv]
// shared types and codes of the sorted term accumulator
`timescale 1ns / 1ps

package sta_pkg;

  // request kinds carried in s_tuser
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // result codes carried in m_tuser
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_COMBINED = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_DROPPED  = 3'd3;
  localparam logic [2:0] ST_READ_OK  = 3'd4;
  localparam logic [2:0] ST_BAD_IDX  = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  // register index of zero_threshold
  localparam logic REG_THRESHOLD = 1'b0;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMP,
    PH_UPD
  } sta_phase_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic capture;  // register compare flags against the pending term
    logic insert;   // open a slot at the insert point, shift later entries up
    logic remove;   // drop the matching entry, shift later entries down
    logic combine;  // matching entry takes the saturated sum
  } sta_cell_ctl_t;

endpackage

[design/sta_cell.sv]
// one table cell: holds a term, compares it with the pending term, shifts
`timescale 1ns / 1ps

module sta_cell #(
  parameter int IDX        = 0,
  parameter int DIM        = 4,
  parameter int EXP_BITS   = 8,
  parameter int CW         = 32,
  parameter int CNTW       = 7
) (
  input  logic                  clk,
  input  sta_pkg::sta_cell_ctl_t ctl,
  input  logic [CNTW-1:0]       count,
  input  logic [30:0]           threshold,
  input  logic [31:0]           new_exp,
  input  logic signed [CW-1:0]  new_coef,
  input  logic [5:0]            rd_idx,
  input  logic                  left_ins,
  input  logic [31:0]           left_exp,
  input  logic signed [CW-1:0]  left_coef,
  input  logic [31:0]           right_exp,
  input  logic signed [CW-1:0]  right_coef,
  output logic [31:0]           exp_q,
  output logic signed [CW-1:0]  coef_q,
  output logic                  ins_q,
  output logic                  eq_q,
  output logic                  kill,
  output logic                  rd_hit,
  output logic [31:0]           rd_exp,
  output logic signed [CW-1:0]  rd_coef
);
  import sta_pkg::*;

  localparam int DW = EXP_BITS + 4;
  localparam logic signed [CW:0] SMAX = (CW+1)'((64'(1) << (CW - 1)) - 64'(1));
  localparam logic signed [CW:0] SMIN = -SMAX - (CW+1)'(1);

  function automatic logic [EXP_BITS-1:0] slot(input logic [31:0] packed_exp, input int v);
    int sh;
    sh = (DIM - 1 - v) * EXP_BITS;
    if (sh >= 32) return '0;
    return EXP_BITS'(packed_exp >> sh);
  endfunction

  function automatic logic [DW-1:0] degree(input logic [31:0] packed_exp);
    logic [DW-1:0] s;
    s = '0;
    for (int v = 0; v < DIM; v++) s = s + DW'(slot(packed_exp, v));
    return s;
  endfunction

  logic              valid;
  logic              new_lt, new_eq;
  logic [DW-1:0]     dn, dc;
  logic              decided;
  logic signed [CW:0] sum, sum_sat, mag;

  assign valid = 32'(count) > 32'(IDX);

  // graded order: degree first, then variable by variable from variable 0
  always_comb begin
    dn = degree(new_exp);
    dc = degree(exp_q);
    new_lt  = dn < dc;
    new_eq  = dn == dc;
    decided = dn != dc;
    for (int v = 0; v < DIM; v++) begin
      if (!decided && slot(new_exp, v) != slot(exp_q, v)) begin
        decided = 1'b1;
        new_eq  = 1'b0;
        new_lt  = slot(new_exp, v) < slot(exp_q, v);
      end
    end
  end

  // saturated sum and zero test for the matching entry
  always_comb begin
    sum = (CW+1)'(coef_q) + (CW+1)'(new_coef);
    if (sum > SMAX)      sum_sat = SMAX;
    else if (sum < SMIN) sum_sat = SMIN;
    else                 sum_sat = sum;
    mag = sum_sat[CW] ? -sum_sat : sum_sat;
  end

  assign kill = eq_q && (33'($unsigned(mag)) < 33'(threshold));

  assign rd_hit  = valid && (32'(rd_idx) == 32'(IDX));
  assign rd_exp  = rd_hit ? exp_q : '0;
  assign rd_coef = rd_hit ? coef_q : '0;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      ins_q <= !valid || new_lt || new_eq;
      eq_q  <= valid && new_eq;
    end
    if (ctl.insert) begin
      if (ins_q && left_ins) begin
        exp_q  <= left_exp;
        coef_q <= left_coef;
      end else if (ins_q) begin
        exp_q  <= new_exp;
        coef_q <= new_coef;
      end
    end
    if (ctl.remove && ins_q) begin
      exp_q  <= right_exp;
      coef_q <= right_coef;
    end
    if (ctl.combine && eq_q) begin
      coef_q <= CW'(sum_sat);
    end
  end

endmodule

[design/sorted_term_accumulator_unit.sv]
// top level of the sorted term accumulator: request sequencing, cell row, apb register
`timescale 1ns / 1ps

// Keeps up to CAPACITY polynomial terms sorted in graded order (total degree, then exponents
// from variable 0) in a row of cells, one term per cell. An add request either inserts the term
// at its sorted place, adds it into an equal stored monomial (removing that entry when the
// magnitude of the saturated sum falls below zero_threshold), or is dropped when the table is
// full. Read returns the entry at read_index, clear empties the table. Every request answers
// with exactly one result transfer. Each request has a compare phase, in which every cell
// compares its term with the request, and an update phase, in which the cells shift or update
// in parallel and the result is loaded into the output register. A new request is taken in the
// update phase; the update waits while the previous result is still held by the output side.
// zero_threshold sits at byte address 0 of the apb port and may be written only while idle.
module sorted_term_accumulator_unit #(
  parameter int CAPACITY   = 64,
  parameter int DIM        = 4,
  parameter int EXP_BITS   = 8,
  parameter int COEFF_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // term_exponents[31:0], term_coefficient[63:32], read_index[69:64]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // term_count[6:0], out_exponents[38:7], out_coefficient[70:39]
  output logic [2:0]  m_tuser,   // status[2:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sta_pkg::*;

  localparam int CW   = (COEFF_BITS > 32) ? 32 : COEFF_BITS;
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam logic signed [31:0] CMAX = 32'((64'(1) << (CW - 1)) - 64'(1));
  localparam logic signed [31:0] CMIN = -CMAX - 32'sd1;

  // apb register
  logic [30:0] threshold;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {1'b0, threshold} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 31'd1;
    end else if (psel && penable && pwrite && paddr[2] == REG_THRESHOLD) begin
      threshold <= pwdata[30:0];
    end
  end

  // pending request, held from accept until its update
  logic [1:0]          req;
  logic [31:0]         req_exp;
  logic signed [CW-1:0] req_coef;
  logic [5:0]          req_idx;
  logic signed [31:0]  in_coef;

  assign in_coef = $signed(s_tdata[63:32]);

  // sequencing
  sta_phase_t    phase, phase_next;
  logic          out_free, fire, accept;
  sta_cell_ctl_t ctl;
  logic [CNTW-1:0] count;

  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: if (s_tvalid) phase_next = PH_CMP;
      PH_CMP:  phase_next = PH_UPD;
      PH_UPD: begin
        if (out_free) phase_next = s_tvalid ? PH_CMP : PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    fire     = 1'b0;
    unique case (phase)
      PH_IDLE: s_tready = 1'b1;
      PH_CMP:  s_tready = 1'b0;
      PH_UPD: begin
        s_tready = out_free;
        fire     = out_free;
      end
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) phase <= PH_IDLE;
    else     phase <= phase_next;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req     <= s_tuser;
      req_exp <= s_tdata[31:0];
      req_idx <= s_tdata[69:64];
      // clamp the incoming coefficient to the stored width
      if (in_coef > CMAX)      req_coef <= CW'(CMAX);
      else if (in_coef < CMIN) req_coef <= CW'(CMIN);
      else                     req_coef <= CW'(in_coef);
    end
  end

  // cell row
  logic [31:0]          c_exp   [CAPACITY];
  logic signed [CW-1:0] c_coef  [CAPACITY];
  logic                 c_ins   [CAPACITY];
  logic                 c_eq    [CAPACITY];
  logic                 c_kill  [CAPACITY];
  logic                 c_hit   [CAPACITY];
  logic [31:0]          c_rexp  [CAPACITY];
  logic signed [CW-1:0] c_rcoef [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 l_ins;
    logic [31:0]          l_exp, r_exp;
    logic signed [CW-1:0] l_coef, r_coef;

    if (i == 0) begin : g_first
      assign l_ins  = 1'b0;
      assign l_exp  = '0;
      assign l_coef = '0;
    end else begin : g_mid
      assign l_ins  = c_ins[i-1];
      assign l_exp  = c_exp[i-1];
      assign l_coef = c_coef[i-1];
    end

    // the last cell has nothing behind it and keeps its own term on a removal
    if (i == CAPACITY - 1) begin : g_last
      assign r_exp  = c_exp[i];
      assign r_coef = c_coef[i];
    end else begin : g_inner
      assign r_exp  = c_exp[i+1];
      assign r_coef = c_coef[i+1];
    end

    sta_cell #(
      .IDX      (i),
      .DIM      (DIM),
      .EXP_BITS (EXP_BITS),
      .CW       (CW),
      .CNTW     (CNTW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count),
      .threshold  (threshold),
      .new_exp    (req_exp),
      .new_coef   (req_coef),
      .rd_idx     (req_idx),
      .left_ins   (l_ins),
      .left_exp   (l_exp),
      .left_coef  (l_coef),
      .right_exp  (r_exp),
      .right_coef (r_coef),
      .exp_q      (c_exp[i]),
      .coef_q     (c_coef[i]),
      .ins_q      (c_ins[i]),
      .eq_q       (c_eq[i]),
      .kill       (c_kill[i]),
      .rd_hit     (c_hit[i]),
      .rd_exp     (c_rexp[i]),
      .rd_coef    (c_rcoef[i])
    );
  end

  // row-wide flags: at most one cell matches or is read, so plain or-gathering selects it
  logic                 found, remove_any, hit;
  logic [31:0]          rd_exp;
  logic signed [CW-1:0] rd_coef;

  always_comb begin
    found      = 1'b0;
    remove_any = 1'b0;
    hit        = 1'b0;
    rd_exp     = '0;
    rd_coef    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found      = found | c_eq[i];
      remove_any = remove_any | c_kill[i];
      hit        = hit | c_hit[i];
      rd_exp     = rd_exp | c_rexp[i];
      rd_coef    = rd_coef | c_rcoef[i];
    end
  end

  // decision for the update cycle
  logic [2:0]      status;
  logic [CNTW-1:0] count_next;
  logic            full;

  assign full = count == CNTW'(CAPACITY);

  always_comb begin
    ctl         = '0;
    ctl.capture = (phase == PH_CMP);
    status      = ST_BAD_IDX;
    count_next  = count;
    case (req)
      REQ_ADD: begin
        if (found && remove_any) begin
          status     = ST_REMOVED;
          ctl.remove = fire;
          count_next = count - CNTW'(1);
        end else if (found) begin
          status      = ST_COMBINED;
          ctl.combine = fire;
        end else if (full) begin
          status = ST_DROPPED;
        end else begin
          status     = ST_INSERTED;
          ctl.insert = fire;
          count_next = count + CNTW'(1);
        end
      end
      REQ_READ:  status = hit ? ST_READ_OK : ST_BAD_IDX;
      REQ_CLEAR: begin
        status     = ST_CLEARED;
        count_next = '0;
      end
      default:   status = ST_BAD_IDX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tuser        <= status;
      m_tdata[6:0]   <= 7'(count_next);
      m_tdata[38:7]  <= (req == REQ_READ) ? rd_exp : '0;
      m_tdata[70:39] <= (req == REQ_READ) ? 32'(rd_coef) : '0;
      m_tdata[71]    <= 1'b0;
    end
  end

endmodule
